// ===== rtl/core/lbrc_pkg.sv =====
// shared types, constants and codes of the block read cache
package lbrc_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned BLK_BITS = 20;
  localparam int unsigned TAG_W    = ADDR_W - BLK_BITS;
  localparam int unsigned WAYS     = 32;
  localparam int unsigned SLOT_W   = $clog2(WAYS);
  localparam int unsigned MAX_SEGS = 16;
  localparam int unsigned BLEN_W   = BLK_BITS + 1;
  localparam int unsigned KIND_W   = 3;

  localparam logic [BLEN_W-1:0] BLK_LEN = BLEN_W'(1) << BLK_BITS;

  localparam logic [KIND_W-1:0] K_ZERO  = 3'd0;
  localparam logic [KIND_W-1:0] K_EOF   = 3'd1;
  localparam logic [KIND_W-1:0] K_BYP   = 3'd2;
  localparam logic [KIND_W-1:0] K_MANY  = 3'd3;
  localparam logic [KIND_W-1:0] K_CACHE = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_EOF  = 2'd1;
  localparam logic [1:0] ST_MANY = 2'd2;

  localparam logic [0:0] REG_FILE_LEN = 1'd0;
  localparam logic [0:0] REG_CACHE_EN = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              raw_data;
  } lbrc_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                bypass;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    fetch_block;
    logic [BLEN_W-1:0]   fetch_len;
    logic                evict_valid;
    logic [TAG_W-1:0]    evict_block;
    logic [BLK_BITS-1:0] in_block_offset;
    logic [SIZE_W-1:0]   copy_len;
    logic [SIZE_W-1:0]   out_offset;
    logic                last;
  } lbrc_res_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } lbrc_desc_t;

  typedef struct packed {
    logic [ADDR_W-1:0] file_len;
    logic              cache_en;
  } lbrc_cfg_t;

endpackage

// ===== rtl/core/lru_block_read_cache_core.sv =====
// top level of the block read cache: config registers, front, queue and back
// one-result items pass the front register, the queue and the result register
// cached requests: a lookup and an update state per segment; the update waits
// for a free result register; throughput: one-result items 1 per cycle while
// results are taken; a cached item holds the back through all its segments
// reset: config cleared, cache entries invalid, queue and result register empty
module lru_block_read_cache_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [47:0]          cfg_data_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  lbrc_pkg::lbrc_req_t  req_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output lbrc_pkg::lbrc_res_t  res_o
);
  import lbrc_pkg::*;

  lbrc_cfg_t  cfg_q;
  logic       push, full, pop, q_valid;
  lbrc_desc_t desc_in, desc_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i && !cfg_idx_i[1]) begin
      if (cfg_idx_i[0] == REG_FILE_LEN) cfg_q.file_len <= cfg_data_i[ADDR_W-1:0];
      if (cfg_idx_i[0] == REG_CACHE_EN) cfg_q.cache_en <= cfg_data_i[0];
    end
  end

  lbrc_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .req_valid_i, .req_ready_o, .req_i,
    .push_o(push), .desc_o(desc_in), .full_i(full)
  );

  lbrc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .desc_i(desc_in), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .desc_o(desc_out)
  );

  lbrc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .valid_i(q_valid), .desc_i(desc_out), .pop_o(pop),
    .res_valid_o, .res_ready_i, .res_o
  );

endmodule

// ===== rtl/core/lbrc_front.sv =====
// request intake and classification
module lbrc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbrc_pkg::lbrc_cfg_t  cfg_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  lbrc_pkg::lbrc_req_t  req_i,
  output logic               push_o,
  output lbrc_pkg::lbrc_desc_t desc_o,
  input  logic               full_i
);
  import lbrc_pkg::*;

  logic              valid_q, valid_d;
  lbrc_req_t         req_q;
  logic [ADDR_W:0]   end_q;
  logic [ADDR_W-1:0] end_m1;
  logic [TAG_W-1:0]  span;

  assign push_o      = valid_q && !full_i;
  assign req_ready_o = !valid_q || !full_i;
  assign end_m1      = end_q[ADDR_W-1:0] - ADDR_W'(1);
  assign span        = end_m1[ADDR_W-1:BLK_BITS] - req_q.addr[ADDR_W-1:BLK_BITS];

  always_comb begin
    desc_o.addr = req_q.addr;
    desc_o.size = req_q.size;
    if (req_q.size == '0) begin
      desc_o.kind = K_ZERO;
    end else if (end_q[ADDR_W] || end_q[ADDR_W-1:0] > cfg_i.file_len) begin
      desc_o.kind = K_EOF;
    end else if (!cfg_i.cache_en || (req_q.raw_data && req_q.size >= SIZE_W'(BLK_LEN))) begin
      desc_o.kind = K_BYP;
    end else if (span >= TAG_W'(MAX_SEGS)) begin
      desc_o.kind = K_MANY;
    end else begin
      desc_o.kind = K_CACHE;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (push_o) valid_d = 1'b0;
    if (req_valid_i && req_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
      end_q <= {1'b0, req_i.addr} + (ADDR_W + 1)'(req_i.size);
    end
  end

endmodule

// ===== rtl/core/lbrc_queue.sv =====
// two-entry queue of classified requests
module lbrc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lbrc_pkg::lbrc_desc_t desc_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output lbrc_pkg::lbrc_desc_t desc_o
);
  import lbrc_pkg::*;

  lbrc_desc_t  mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign desc_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= desc_i;
  end

endmodule

// ===== rtl/core/lbrc_back.sv =====
// segment walk, tag lookup, lru update and result register
module lbrc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbrc_pkg::lbrc_cfg_t  cfg_i,
  input  logic               valid_i,
  input  lbrc_pkg::lbrc_desc_t desc_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output lbrc_pkg::lbrc_res_t  res_o
);
  import lbrc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              out_v_q, out_v_d;
  lbrc_res_t         out_q;
  logic [ADDR_W-1:0] pos_q, base_q;
  logic [SIZE_W-1:0] rem_q;

  logic [TAG_W-1:0]  tags_q  [WAYS];
  logic [SLOT_W-1:0] rank_q  [WAYS];
  logic [WAYS-1:0]   valid_q;

  logic              hit_q, evict_q;
  logic [SLOT_W-1:0] slot_q, hrank_q;
  logic [TAG_W-1:0]  eblk_q;
  logic [BLEN_W-1:0] blen_q;

  logic              out_free;
  logic [TAG_W-1:0]  blk;
  logic [ADDR_W-1:0] avail;
  logic              found, has_free;
  logic [SLOT_W-1:0] hit_idx, free_idx, old_idx, pick;
  logic [BLEN_W-1:0] room;
  logic [SIZE_W-1:0] clen, rem_next;
  lbrc_res_t         seg;
  lbrc_res_t         single_res;

  assign out_free    = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
  assign blk         = pos_q[ADDR_W-1:BLK_BITS];
  assign avail       = cfg_i.file_len - {blk, BLK_BITS'(0)};
  assign pop_o       = (state_q == S_IDLE) && valid_i && (desc_i.kind == K_CACHE || out_free);

  // lowest hit, lowest free entry, and the oldest entry when full
  always_comb begin
    found = 1'b0;
    has_free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    old_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_q[i] && tags_q[i] == blk) begin
        found = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (rank_q[i] == SLOT_W'(WAYS - 1)) old_idx = SLOT_W'(i);
    end
    pick = found ? hit_idx : (has_free ? free_idx : old_idx);
  end

  // one-result item for zero length, past end of file, bypass and too many segments
  always_comb begin
    single_res = '0;
    single_res.last = 1'b1;
    case (desc_i.kind)
      K_EOF:  single_res.status = ST_EOF;
      K_MANY: single_res.status = ST_MANY;
      K_BYP: begin
        single_res.bypass   = 1'b1;
        single_res.copy_len = desc_i.size;
      end
      default: ;
    endcase
  end

  always_comb begin
    room     = blen_q - BLEN_W'(pos_q[BLK_BITS-1:0]);
    clen     = (rem_q < SIZE_W'(room)) ? rem_q : SIZE_W'(room);
    rem_next = rem_q - clen;
    seg = '0;
    seg.status          = ST_OK;
    seg.hit             = hit_q;
    seg.slot            = slot_q;
    seg.fetch_block     = hit_q ? '0 : blk;
    seg.fetch_len       = hit_q ? '0 : blen_q;
    seg.evict_valid     = evict_q;
    seg.evict_block     = evict_q ? eblk_q : '0;
    seg.in_block_offset = pos_q[BLK_BITS-1:0];
    seg.copy_len        = clen;
    seg.out_offset      = SIZE_W'(pos_q - base_q);
    seg.last            = rem_next == '0;
  end

  always_comb begin
    state_d = state_q;
    out_v_d = out_v_q && !res_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          if (desc_i.kind == K_CACHE) state_d = S_LOOK;
          else out_v_d = 1'b1;
        end
      end
      S_LOOK: state_d = S_UPD;
      S_UPD: begin
        if (out_free) begin
          out_v_d = 1'b1;
          state_d = (rem_next == '0) ? S_IDLE : S_LOOK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      if (state_q == S_UPD && out_free && !hit_q) valid_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_o) begin
      if (desc_i.kind == K_CACHE) begin
        pos_q  <= desc_i.addr;
        base_q <= desc_i.addr;
        rem_q  <= desc_i.size;
      end else begin
        out_q <= single_res;
      end
    end
    if (state_q == S_LOOK) begin
      hit_q   <= found;
      evict_q <= !found && !has_free;
      slot_q  <= pick;
      hrank_q <= rank_q[hit_idx];
      eblk_q  <= tags_q[old_idx];
      blen_q  <= (avail < ADDR_W'(BLK_LEN)) ? BLEN_W'(avail) : BLK_LEN;
    end
    if (state_q == S_UPD && out_free) begin
      out_q <= seg;
      pos_q <= pos_q + ADDR_W'(clen);
      rem_q <= rem_next;
      for (int i = 0; i < WAYS; i++) begin
        if (valid_q[i] && SLOT_W'(i) != slot_q && (!hit_q || rank_q[i] < hrank_q)) begin
          rank_q[i] <= rank_q[i] + SLOT_W'(1);
        end
      end
      rank_q[slot_q] <= '0;
      if (!hit_q) tags_q[slot_q] <= blk;
    end
  end

endmodule
